FILE: rtl/first_child_with_children_search_core_macros.svh
// Assertion macros shared by the search core RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef FIRST_CHILD_WITH_CHILDREN_SEARCH_CORE_MACROS_SVH
`define FIRST_CHILD_WITH_CHILDREN_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("FCS assertion failed");

// Next-cycle implication, disabled during reset.
`define FCS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("FCS assertion failed");

`endif

FILE: rtl/fcs_pkg.sv
// Shared types, field widths and operation codes of the search core.
// Depends on nothing; used by the interfaces, the cell and the top level.
`default_nettype none

package fcs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int LINK_BITS_DEFAULT   = 8;

   localparam int OP_BITS    = 1;
   localparam int INDEX_BITS = 6;
   localparam int TAG_BITS   = 8;
   localparam int COUNT_BITS = 7;
   localparam int RESULT_BITS = 7;

   localparam logic [OP_BITS-1:0] OP_WRITE  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_SEARCH = 1'b1;

   typedef struct packed {
      logic shift;
      logic load;
      logic write;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/fcs_req_if.sv
// Request channel interface: valid/ready handshake with write and search fields.
// Depends on fcs_pkg.
`default_nettype none

interface fcs_req_if;
   import fcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [INDEX_BITS-1:0] entry_index;
   logic [TAG_BITS-1:0]   entry_link;
   logic [TAG_BITS-1:0]   query_parent;

   modport source (
      output valid, operation, entry_index, entry_link, query_parent,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, entry_link, query_parent,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/fcs_rsp_if.sv
// Response channel interface: valid/ready handshake with result index and flag.
// Depends on fcs_pkg.
`default_nettype none

interface fcs_rsp_if;
   import fcs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RESULT_BITS-1:0] result_index;
   logic                   found;

   modport source (
      output valid, result_index, found,
      input  ready
   );
   modport sink (
      input  valid, result_index, found,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/fcs_cell.sv
// One table cell: holds a link and its in-range flag, rotates them to its neighbour.
// Depends on fcs_pkg.
`default_nettype none

module fcs_cell #(
   parameter int POSITION  = 0,
   parameter int LINK_BITS = fcs_pkg::LINK_BITS_DEFAULT,
   parameter int CAND_BITS = 6,
   parameter int CNT_BITS  = 7
) (
   input  wire                           clock,
   input  fcs_pkg::cell_ctrl_type        ctrl,
   input  wire [fcs_pkg::INDEX_BITS-1:0] wr_index,
   input  wire [LINK_BITS-1:0]           wr_link,
   input  wire [CNT_BITS-1:0]            count,
   input  wire [CAND_BITS-1:0]           cand,
   input  wire [LINK_BITS-1:0]           link_next,
   input  wire                           range_next,
   output logic [LINK_BITS-1:0]          link_out,
   output logic                          range_out,
   output logic                          hit
);
   import fcs_pkg::*;

   localparam int CMP_BITS = (LINK_BITS > CAND_BITS) ? LINK_BITS : CAND_BITS;

   logic [LINK_BITS-1:0] link_ff;
   logic                 range_ff;

   always_ff @(posedge clock) begin
      if (ctrl.write && (int'(wr_index) == POSITION)) begin
         link_ff <= wr_link;
      end else if (ctrl.shift) begin
         link_ff <= link_next;
      end
      if (ctrl.load) begin
         range_ff <= (POSITION < int'(count));
      end else if (ctrl.shift) begin
         range_ff <= range_next;
      end
   end

   assign link_out  = link_ff;
   assign range_out = range_ff;
   assign hit       = range_ff && (CMP_BITS'(link_ff) == CMP_BITS'(cand));

endmodule

`default_nettype wire

FILE: rtl/first_child_with_children_search_core.sv
// Top level of the search core: control, result register and the rotating cell row.
// Depends on fcs_pkg, fcs_req_if, fcs_rsp_if, fcs_cell and the assertion macros.
//
//   Port       Direction  Beat contents
//   req_chan   in         operation, entry_index, entry_link, query_parent
//   rsp_chan   out        result_index, found
//   csr_*      in         live entry limit (write only)
//
// A write beat's acknowledge appears the cycle after the beat is taken.
// During a search the cell row rotates one entry per cycle past the head cell while every
// cell compares its link with the candidate index at once.
// Reset is synchronous and clears control and the limit register; the table is not cleared.
// A stalled response holds the block: no request is taken until the result leaves.
`default_nettype none

module first_child_with_children_search_core #(
   parameter int TABLE_DEPTH = fcs_pkg::TABLE_DEPTH_DEFAULT,
   parameter int LINK_BITS   = fcs_pkg::LINK_BITS_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   fcs_req_if.sink                       req_chan,
   fcs_rsp_if.source                     rsp_chan,
   input  wire                           csr_wr_en,
   input  wire [fcs_pkg::COUNT_BITS-1:0] csr_wr_data
);
   import fcs_pkg::*;

`include "first_child_with_children_search_core_macros.svh"

   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_BITS = (CNT_BITS > COUNT_BITS) ? CNT_BITS : COUNT_BITS;
   localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(TABLE_DEPTH - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [IDX_BITS-1:0]    step_ff, step_in;
   logic [LINK_BITS-1:0]   query_ff, query_in;
   logic [CNT_BITS-1:0]    n_ff, n_in;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [COUNT_BITS-1:0]  count_ff;

   logic                   req_accept;
   logic                   out_free;
   logic [CNT_BITS-1:0]    n_eff;
   logic                   qualify;
   cell_ctrl_type          ctrl;

   logic [LINK_BITS-1:0]   link_w  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] range_w;
   logic [TABLE_DEPTH-1:0] hit_w;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign n_eff = (EXT_BITS'(count_ff) > EXT_BITS'(TABLE_DEPTH)) ?
                  CNT_BITS'(TABLE_DEPTH) : CNT_BITS'(count_ff);

   assign ctrl.shift = (state_ff == ST_SEARCH);
   assign ctrl.load  = req_accept && (req_chan.operation == OP_SEARCH);
   assign ctrl.write = req_accept && (req_chan.operation == OP_WRITE);

   for (genvar p = 0; p < TABLE_DEPTH; p++) begin : g_cell
      localparam int NEXT_POS = (p + 1) % TABLE_DEPTH;
      fcs_cell #(
         .POSITION  (p),
         .LINK_BITS (LINK_BITS),
         .CAND_BITS (IDX_BITS),
         .CNT_BITS  (CNT_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wr_index   (req_chan.entry_index),
         .wr_link    (LINK_BITS'(req_chan.entry_link)),
         .count      (n_eff),
         .cand       (step_ff),
         .link_next  (link_w[NEXT_POS]),
         .range_next (range_w[NEXT_POS]),
         .link_out   (link_w[p]),
         .range_out  (range_w[p]),
         .hit        (hit_w[p])
      );
   end

   assign qualify = range_w[0] && (link_w[0] == query_ff) && (|hit_w);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      query_in     = query_ff;
      n_in         = n_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.operation == OP_SEARCH) begin
                  state_in = ST_SEARCH;
                  step_in  = '0;
                  query_in = LINK_BITS'(req_chan.query_parent);
                  n_in     = n_eff;
                  found_in = 1'b0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_index_in = '0;
                  rsp_found_in = 1'b0;
               end
            end
         end
         ST_SEARCH: begin
            step_in = step_ff + IDX_BITS'(1);
            if (qualify && !found_ff) begin
               found_in = 1'b1;
               idx_in   = step_ff;
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_index_in = found_ff ? RESULT_BITS'(idx_ff) : RESULT_BITS'(n_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
      step_ff      <= step_in;
      query_ff     <= query_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.found        = rsp_found_ff;

   `FCS_ASSERT_IMP(a_accept_only_idle, clock, reset,
      req_chan.valid && req_chan.ready, state_ff == ST_IDLE)
   `FCS_ASSERT_NXT(a_search_ends, clock, reset,
      (state_ff == ST_SEARCH) && (step_ff == LAST_STEP), state_ff == ST_FINISH)
   `FCS_ASSERT_IMP(a_found_in_range, clock, reset,
      found_ff, EXT_BITS'(idx_ff) < EXT_BITS'(n_ff))
   `FCS_ASSERT_NXT(a_search_start, clock, reset,
      req_accept && (req_chan.operation == OP_SEARCH),
      (state_ff == ST_SEARCH) && !found_ff)

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for first_child_with_children_search_core: queued write and search beats,
// an in-bench table predictor and a response checker, with random gaps on both channels.
// Depends on fcs_pkg, fcs_req_if, fcs_rsp_if and the core itself.
`default_nettype none

module tb_top;
   import fcs_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEFAULT;

   typedef struct packed {
      logic [OP_BITS-1:0]    operation;
      logic [INDEX_BITS-1:0] entry_index;
      logic [TAG_BITS-1:0]   entry_link;
      logic [TAG_BITS-1:0]   query_parent;
   } req_beat_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] result_index;
      logic                   found;
   } rsp_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   fcs_req_if req_bus ();
   fcs_rsp_if rsp_bus ();

   first_child_with_children_search_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   req_beat_type          pending_beats[$];
   rsp_beat_type          awaited_results[$];
   rsp_beat_type          oldest_result;
   logic [TAG_BITS-1:0]   link_table[TABLE_DEPTH];
   logic [TAG_BITS-1:0]   planned_links[TABLE_DEPTH];
   logic [COUNT_BITS-1:0] live_count_cfg = '0;
   int                    beats_taken = 0;
   int                    mismatch_count = 0;

   // A long stretch of the run goes without any gaps on either channel.
   wire calm = beats_taken >= 600 && beats_taken < 900;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int live_entries();
      return (live_count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count_cfg);
   endfunction

   // Updates the table copy for a write, or finds the first entry linked to the
   // queried tag that is itself the parent of some entry in range.
   function automatic rsp_beat_type apply_request(req_beat_type beat);
      rsp_beat_type outcome;
      int           n;
      outcome = '0;
      n = live_entries();
      if (beat.operation == OP_WRITE) begin
         link_table[beat.entry_index] = beat.entry_link;
         return outcome;
      end
      for (int i = 0; i < n; i++) begin
         if (link_table[i] == beat.query_parent) begin
            for (int j = 0; j < n; j++) begin
               if (link_table[j] == TAG_BITS'(i)) begin
                  outcome.result_index = RESULT_BITS'(i);
                  outcome.found = 1'b1;
                  return outcome;
               end
            end
         end
      end
      outcome.result_index = RESULT_BITS'(n);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_results.push_back(apply_request(pending_beats.pop_front()));
            beats_taken <= beats_taken + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
               req_bus.valid        <= 1'b1;
               req_bus.operation    <= pending_beats[0].operation;
               req_bus.entry_index  <= pending_beats[0].entry_index;
               req_bus.entry_link   <= pending_beats[0].entry_link;
               req_bus.query_parent <= pending_beats[0].query_parent;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got index %0d found %0b",
                        $time, rsp_bus.result_index, rsp_bus.found);
               mismatch_count++;
            end else begin
               oldest_result = awaited_results.pop_front();
               if (rsp_bus.result_index !== oldest_result.result_index) begin
                  $display("%0t: result_index mismatch, expected %0d, got %0d",
                           $time, oldest_result.result_index, rsp_bus.result_index);
                  mismatch_count++;
               end
               if (rsp_bus.found !== oldest_result.found) begin
                  $display("%0t: found mismatch, expected %0b, got %0b",
                           $time, oldest_result.found, rsp_bus.found);
                  mismatch_count++;
               end
            end
         end
         rsp_bus.ready <= calm || $urandom_range(99) >= 25;
      end
   end

   task automatic queue_write(int idx, int link);
      req_beat_type beat;
      beat.operation    = OP_WRITE;
      beat.entry_index  = INDEX_BITS'(idx);
      beat.entry_link   = TAG_BITS'(link);
      beat.query_parent = TAG_BITS'($urandom_range(255));
      planned_links[idx] = TAG_BITS'(link);
      pending_beats.push_back(beat);
   endtask

   task automatic queue_search(int query);
      req_beat_type beat;
      beat.operation    = OP_SEARCH;
      beat.entry_index  = INDEX_BITS'($urandom_range(TABLE_DEPTH - 1));
      beat.entry_link   = TAG_BITS'($urandom_range(255));
      beat.query_parent = TAG_BITS'(query);
      pending_beats.push_back(beat);
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || awaited_results.size() != 0 || req_bus.valid) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_live_count(int value);
      wait_idle();
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= COUNT_BITS'(value);
      live_count_cfg  = COUNT_BITS'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Links lean towards tags inside the live range so that parent chains form.
   task automatic queue_random_phase(int beats);
      int n;
      int r;
      n = live_entries();
      for (int k = 0; k < beats; k++) begin
         r = $urandom_range(9);
         if ($urandom_range(1) == 0) begin
            if (r < 5 && n > 0) begin
               queue_write($urandom_range(63), $urandom_range(n - 1));
            end else if (r < 7) begin
               queue_write($urandom_range(63), $urandom_range(TABLE_DEPTH - 1));
            end else if (r < 9) begin
               queue_write($urandom_range(63), $urandom_range(255));
            end else begin
               queue_write($urandom_range(63), $urandom_range(1) ? 0 : 255);
            end
         end else begin
            if (r < 5 && n > 0) begin
               queue_search(planned_links[$urandom_range(n - 1)]);
            end else if (r < 8) begin
               queue_search($urandom_range(TABLE_DEPTH - 1));
            end else begin
               queue_search($urandom_range(255));
            end
         end
      end
   endtask

   initial begin
      int phase_counts[7];
      phase_counts = '{64, 1, 127, 0, 65, 2, 64};
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_WRITE;
      req_bus.entry_index  = '0;
      req_bus.entry_link   = '0;
      req_bus.query_parent = '0;
      rsp_bus.ready        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table searches, then a small tree with an outside root.
      queue_search(0);
      queue_search(255);
      queue_write(0, 200);
      queue_write(1, 0);
      queue_write(2, 0);
      queue_write(3, 1);
      queue_write(63, 255);
      queue_write(62, 0);
      set_live_count(4);
      queue_search(0);
      queue_search(200);
      queue_search(1);
      queue_search(255);
      queue_write(3, 3);
      queue_search(3);
      queue_search(1);
      queue_write(0, 0);
      queue_search(0);

      // Every entry is written before any wider count lets a search read it.
      for (int idx = 4; idx < 62; idx++) begin
         queue_write(idx, $urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(idx));
         if (idx % 3 == 0) begin
            queue_search($urandom_range(7));
         end
      end

      for (int p = 0; p < 14; p++) begin
         if (p < 7) begin
            set_live_count(phase_counts[p]);
         end else begin
            set_live_count($urandom_range(3) == 0 ? $urandom_range(127, 65)
                                                  : $urandom_range(64, 1));
         end
         queue_random_phase(120);
      end

      wait_idle();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
